// ===== rtl/dithered_gradient_rgb565_assert.svh =====
// Assertion macros shared by the dithered gradient RTL.
`ifndef DITHERED_GRADIENT_RGB565_ASSERT_SVH
`define DITHERED_GRADIENT_RGB565_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define DGR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define DGR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/dgr_pkg.sv =====
// Shared types, constants and tables for the dithered gradient generator.
package dgr_pkg;

  // Field widths.
  localparam int PIX_W   = 11;
  localparam int COLOR_W = 16;
  localparam int START_W = 12;
  localparam int END_W   = 13;
  localparam int DIM_W   = 12;

  // Largest frame dimension; larger width or height settings saturate here.
  localparam int MAX_DIM = 2048;

  // Row arithmetic width: holds any row offset and any span.
  localparam int ROW_W = $clog2(MAX_DIM + 1);

  // Signed width used for band limit compares.
  localparam int SROW_W = END_W + 1;

  // Blend factor has 8 fraction bits and can reach 1.0, so 9 quotient bits.
  localparam int FRAC_W = 8;
  localparam int QUO_W  = FRAC_W + 1;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TOP_COLOR    = 3'd0,
    REG_BOTTOM_COLOR = 3'd1,
    REG_START_ROW    = 3'd2,
    REG_END_ROW      = 3'd3,
    REG_FRAME_WIDTH  = 3'd4,
    REG_FRAME_HEIGHT = 3'd5
  } dgr_reg_t;

  // Reset values of the frame size registers.
  localparam logic [DIM_W-1:0] WIDTH_RST  = DIM_W'(320);
  localparam logic [DIM_W-1:0] HEIGHT_RST = DIM_W'(240);

  // Channel saturation limits.
  localparam logic [5:0] LIM_RB = 6'd31;
  localparam logic [5:0] LIM_G  = 6'd63;

  // 4x4 ordered dither matrix, indexed [y & 3][x & 3].
  localparam logic [3:0] DITHER_TAB [4][4] = '{
    '{4'd0,  4'd8,  4'd2,  4'd10},
    '{4'd12, 4'd4,  4'd14, 4'd6},
    '{4'd3,  4'd11, 4'd1,  4'd9},
    '{4'd15, 4'd7,  4'd13, 4'd5}
  };

  // Per-pixel data that rides along the divider chain.
  typedef struct packed {
    logic       in_band;
    logic [1:0] dith_y;
    logic [1:0] dith_x;
  } dgr_side_t;

endpackage

// ===== rtl/dgr_front.sv =====
// Input stage: band and frame checks, row offset and divisor span.
module dgr_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [dgr_pkg::PIX_W-1:0]     pixel_x,
  input  logic [dgr_pkg::PIX_W-1:0]     pixel_y,
  input  logic [dgr_pkg::START_W-1:0]   start_row,
  input  logic [dgr_pkg::END_W-1:0]     end_row,
  input  logic [dgr_pkg::DIM_W-1:0]     frame_width,
  input  logic [dgr_pkg::DIM_W-1:0]     frame_height,
  output logic [dgr_pkg::ROW_W-1:0]     span,
  output logic                          valid_r,
  output logic [dgr_pkg::ROW_W-1:0]     offset_r,
  output dgr_pkg::dgr_side_t            side_r
);

  localparam int SW = dgr_pkg::SROW_W;
  localparam int RW = dgr_pkg::ROW_W;

  logic [RW-1:0]        width_sat;
  logic [RW-1:0]        height_sat;
  logic signed [SW-1:0] y0_s;
  logic signed [SW-1:0] y1_s;
  logic signed [SW-1:0] end_s;
  logic signed [SW-1:0] y_s;
  logic signed [SW-1:0] band_len;
  logic [RW-1:0]        offset_nxt;
  dgr_pkg::dgr_side_t   side_nxt;

  // Saturate the frame size and clamp the band limits to the frame.
  always_comb begin
    width_sat  = (frame_width > dgr_pkg::DIM_W'(dgr_pkg::MAX_DIM)) ?
                 RW'(dgr_pkg::MAX_DIM) : RW'(frame_width);
    height_sat = (frame_height > dgr_pkg::DIM_W'(dgr_pkg::MAX_DIM)) ?
                 RW'(dgr_pkg::MAX_DIM) : RW'(frame_height);
    y0_s  = start_row[dgr_pkg::START_W-1] ? '0 :
            $signed(SW'({1'b0, start_row[dgr_pkg::START_W-2:0]}));
    end_s = $signed({end_row[dgr_pkg::END_W-1], end_row});
    y1_s  = (end_s > $signed(SW'(height_sat))) ? $signed(SW'(height_sat)) : end_s;
    y_s   = $signed(SW'(pixel_y));
  end

  // The divisor is the band length minus one, never below one.
  always_comb begin
    band_len = y1_s - y0_s;
    span     = (band_len > $signed(SW'(1))) ? RW'(band_len - $signed(SW'(1))) : RW'(1);
  end

  // Band membership and the offset of the row inside the band.
  always_comb begin
    side_nxt.in_band = (RW'(pixel_x) < width_sat) && (y_s >= y0_s) && (y_s < y1_s);
    side_nxt.dith_y  = pixel_y[1:0];
    side_nxt.dith_x  = pixel_x[1:0];
    offset_nxt       = RW'(pixel_y) - RW'(y0_s);
  end

  // Stage register: the valid flag is control, the rest is payload.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      offset_r <= offset_nxt;
      side_r   <= side_nxt;
    end
  end

endmodule

// ===== rtl/dgr_cell.sv =====
// One restoring division cell: resolves one bit of the blend factor.
module dgr_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          valid_in,
  input  logic [dgr_pkg::ROW_W:0]       part_in,
  input  logic [dgr_pkg::QUO_W-1:0]     quo_in,
  input  dgr_pkg::dgr_side_t            side_in,
  input  logic [dgr_pkg::ROW_W-1:0]     span,
  output logic                          valid_r,
  output logic [dgr_pkg::ROW_W-1:0]     rem_r,
  output logic [dgr_pkg::QUO_W-1:0]     quo_r,
  output dgr_pkg::dgr_side_t            side_r
);

  localparam int RW = dgr_pkg::ROW_W;
  localparam int QW = dgr_pkg::QUO_W;

  logic          take;
  logic [RW:0]   diff;
  logic [RW-1:0] rem_nxt;
  logic [QW-1:0] quo_nxt;

  // Subtract the divisor when it fits and shift the result bit in.
  always_comb begin
    take    = part_in >= {1'b0, span};
    diff    = part_in - {1'b0, span};
    rem_nxt = take ? diff[RW-1:0] : part_in[RW-1:0];
    quo_nxt = {quo_in[QW-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      quo_r  <= quo_nxt;
      side_r <= side_in;
    end
  end

endmodule

// ===== rtl/dgr_mix.sv =====
// Output stage: channel blend, ordered dither, saturation and result register.
module dgr_mix (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          valid_in,
  input  logic [dgr_pkg::QUO_W-1:0]     factor,
  input  dgr_pkg::dgr_side_t            side_in,
  input  logic [dgr_pkg::COLOR_W-1:0]   top_color,
  input  logic [dgr_pkg::COLOR_W-1:0]   bottom_color,
  output logic                          valid_r,
  output logic [dgr_pkg::COLOR_W-1:0]   color_r,
  output logic                          band_r
);

  // Blend one channel at four extra fraction bits, add dither, saturate.
  function automatic logic [5:0] mix_chan(input logic [5:0] a, input logic [5:0] b,
                                          input logic [8:0] f, input logic [3:0] d,
                                          input logic [5:0] lim);
    logic signed [17:0] diff;
    logic signed [17:0] prod;
    logic signed [17:0] prod_adj;
    logic signed [17:0] c16;
    logic signed [17:0] sum;
    logic signed [17:0] chan;
    diff     = $signed({12'd0, b}) - $signed({12'd0, a});
    prod     = diff * $signed({9'd0, f});
    // The arithmetic shift rounds toward minus infinity, so bias negative products to truncate toward zero.
    prod_adj = prod + (prod[17] ? 18'sd15 : 18'sd0);
    c16      = $signed({8'd0, a, 4'd0}) + (prod_adj >>> 4);
    sum      = c16 + $signed({14'd0, d});
    chan     = sum >>> 4;
    if (chan > $signed({12'd0, lim})) begin
      chan = $signed({12'd0, lim});
    end
    if (chan < 18'sd0) begin
      chan = 18'sd0;
    end
    return chan[5:0];
  endfunction

  logic [3:0]                  dith;
  logic [4:0]                  red;
  logic [5:0]                  green;
  logic [4:0]                  blue;
  logic [5:0]                  red_w;
  logic [5:0]                  blue_w;
  logic [dgr_pkg::COLOR_W-1:0] color_nxt;

  always_comb begin
    dith   = dgr_pkg::DITHER_TAB[side_in.dith_y][side_in.dith_x];
    red_w  = mix_chan({1'b0, top_color[15:11]}, {1'b0, bottom_color[15:11]}, factor, dith,
                      dgr_pkg::LIM_RB);
    green  = mix_chan(top_color[10:5], bottom_color[10:5], factor, dith, dgr_pkg::LIM_G);
    blue_w = mix_chan({1'b0, top_color[4:0]}, {1'b0, bottom_color[4:0]}, factor, dith,
                      dgr_pkg::LIM_RB);
    red    = red_w[4:0];
    blue   = blue_w[4:0];
    // Pixels outside the band or frame come out black.
    color_nxt = side_in.in_band ? {red, green, blue} : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      color_r <= color_nxt;
      band_r  <= side_in.in_band;
    end
  end

endmodule

// ===== rtl/dithered_gradient_rgb565.sv =====
// Top level of the dithered vertical gradient generator.
// One RGB565 pixel transaction is accepted per clock unless the chain holds,
// and it passes through one input stage, a chain of nine division cells that
// each resolve one bit of the 9-bit blend factor (row offset * 256 / span),
// and one output stage that blends, dithers and saturates the three channels.
// The whole chain advances together; it holds only while a finished result
// waits on out_ready, so in_ready follows out_ready whenever the output
// register is full. Configuration writes are always accepted (cfg_ready is
// tied high) and must be made only while no pixel is in flight.
`include "dithered_gradient_rgb565_assert.svh"

module dithered_gradient_rgb565 (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [dgr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dgr_pkg::COLOR_W-1:0]       cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [dgr_pkg::PIX_W-1:0]         in_pixel_x,
  input  logic [dgr_pkg::PIX_W-1:0]         in_pixel_y,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [dgr_pkg::COLOR_W-1:0]       out_pixel_color,
  output logic                              out_in_band
);

  localparam int RW = dgr_pkg::ROW_W;
  localparam int QW = dgr_pkg::QUO_W;

  logic [dgr_pkg::COLOR_W-1:0] top_color_r;
  logic [dgr_pkg::COLOR_W-1:0] bottom_color_r;
  logic [dgr_pkg::START_W-1:0] start_row_r;
  logic [dgr_pkg::END_W-1:0]   end_row_r;
  logic [dgr_pkg::DIM_W-1:0]   frame_width_r;
  logic [dgr_pkg::DIM_W-1:0]   frame_height_r;

  logic                        en;
  logic [RW-1:0]               span;
  logic                        front_valid;
  logic [RW-1:0]               front_offset;
  dgr_pkg::dgr_side_t          front_side;

  logic                        cell_valid [QW];
  logic [RW-1:0]               cell_rem   [QW];
  logic [QW-1:0]               cell_quo   [QW];
  dgr_pkg::dgr_side_t          cell_side  [QW];

  // Configuration registers; unknown indexes are ignored.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_color_r    <= '0;
      bottom_color_r <= '0;
      start_row_r    <= '0;
      end_row_r      <= '0;
      frame_width_r  <= dgr_pkg::WIDTH_RST;
      frame_height_r <= dgr_pkg::HEIGHT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (dgr_pkg::dgr_reg_t'(cfg_index))
        dgr_pkg::REG_TOP_COLOR:    top_color_r    <= cfg_data;
        dgr_pkg::REG_BOTTOM_COLOR: bottom_color_r <= cfg_data;
        dgr_pkg::REG_START_ROW:    start_row_r    <= cfg_data[dgr_pkg::START_W-1:0];
        dgr_pkg::REG_END_ROW:      end_row_r      <= cfg_data[dgr_pkg::END_W-1:0];
        dgr_pkg::REG_FRAME_WIDTH:  frame_width_r  <= cfg_data[dgr_pkg::DIM_W-1:0];
        dgr_pkg::REG_FRAME_HEIGHT: frame_height_r <= cfg_data[dgr_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // The chain moves whenever the output register is empty or being drained.
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  dgr_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (en),
    .in_valid     (in_valid),
    .pixel_x      (in_pixel_x),
    .pixel_y      (in_pixel_y),
    .start_row    (start_row_r),
    .end_row      (end_row_r),
    .frame_width  (frame_width_r),
    .frame_height (frame_height_r),
    .span         (span),
    .valid_r      (front_valid),
    .offset_r     (front_offset),
    .side_r       (front_side)
  );

  // Division chain: the first cell sees the bare offset, later cells the
  // previous remainder shifted up by one bit.
  for (genvar i = 0; i < QW; i++) begin : g_cell
    if (i == 0) begin : g_first
      dgr_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .valid_in (front_valid),
        .part_in  ({1'b0, front_offset}),
        .quo_in   ('0),
        .side_in  (front_side),
        .span     (span),
        .valid_r  (cell_valid[i]),
        .rem_r    (cell_rem[i]),
        .quo_r    (cell_quo[i]),
        .side_r   (cell_side[i])
      );
    end else begin : g_next
      dgr_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .valid_in (cell_valid[i-1]),
        .part_in  ({cell_rem[i-1], 1'b0}),
        .quo_in   (cell_quo[i-1]),
        .side_in  (cell_side[i-1]),
        .span     (span),
        .valid_r  (cell_valid[i]),
        .rem_r    (cell_rem[i]),
        .quo_r    (cell_quo[i]),
        .side_r   (cell_side[i])
      );
    end
  end

  dgr_mix u_mix (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (en),
    .valid_in     (cell_valid[QW-1]),
    .factor       (cell_quo[QW-1]),
    .side_in      (cell_side[QW-1]),
    .top_color    (top_color_r),
    .bottom_color (bottom_color_r),
    .valid_r      (out_valid),
    .color_r      (out_pixel_color),
    .band_r       (out_in_band)
  );

  // A pixel outside the band or frame must come out black.
  `DGR_ASSERT_NOW(a_out_black, out_valid && !out_in_band, out_pixel_color == '0,
                  "out-of-band pixel has a nonzero color")

  // A waiting result must stall the input side.
  `DGR_ASSERT_NOW(a_stall_in, out_valid && !out_ready, !in_ready,
                  "input accepted while the result register is blocked")

  // The result register only fills from a valid last cell.
  `DGR_ASSERT_NEXT(a_out_from_chain, en && !cell_valid[QW-1], !out_valid,
                   "result valid without a valid item in the last cell")

  // A blocked result keeps its payload.
  `DGR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
                   out_valid && $stable(out_pixel_color) && $stable(out_in_band),
                   "stalled result changed")

endmodule
